### rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Implication checked on the next clock after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
	`ASSERT_CLK(label, (ante) |=> (cons), msg)

`endif

### rtl/core/tpot_pkg.sv
// ----------------------------------------------------------------------------
// tpot_pkg
// Types, widths and index tables for the triangle pair overlap test.
// ----------------------------------------------------------------------------
package tpot_pkg;

	localparam int COORD_BITS = 21;
	localparam int VERT_W     = 63;
	localparam int TAG_W      = 16;

	// coordinate after one subtraction
	localparam int DW   = COORD_BITS + 1;
	// edge-by-edge cross product component
	localparam int NW   = 2 * DW + 1;
	// edge-by-normal cross product component
	localparam int PW   = DW + NW + 1;
	// split of an axis component for the dot-product multipliers
	localparam int HW   = (PW + 1) / 2;
	localparam int LOPW = HW + 1 + DW;
	localparam int HIPW = PW - HW + DW;
	// sum of three axis-by-point products
	localparam int DOTW = PW + DW + 2;

	localparam int N_X1  = 11;
	localparam int N_X2  = 6;
	localparam int N_AX  = N_X1 + N_X2;
	localparam int N_PT  = 6;

	// cyclic successor and predecessor of a component index
	localparam int NXT [3] = '{1, 2, 0};
	localparam int PRV [3] = '{2, 0, 1};

	// edge indices (0..2 triangle A, 3..5 triangle B) of the first-level crosses
	localparam int CROSS_L [N_X1] = '{0, 3, 0, 0, 0, 1, 1, 1, 2, 2, 2};
	localparam int CROSS_R [N_X1] = '{1, 4, 3, 4, 5, 3, 4, 5, 3, 4, 5};

	typedef struct packed {
		logic [TAG_W-1:0]  pair_tag;
		logic [VERT_W-1:0] vertex_b3;
		logic [VERT_W-1:0] vertex_b2;
		logic [VERT_W-1:0] vertex_b1;
		logic [VERT_W-1:0] vertex_a3;
		logic [VERT_W-1:0] vertex_a2;
		logic [VERT_W-1:0] vertex_a1;
	} pair_t;

	typedef struct packed {
		logic             overlaps;
		logic [TAG_W-1:0] result_tag;
	} result_t;

	function automatic logic signed [COORD_BITS-1:0] coord(logic [VERT_W-1:0] v, int k);
		return v[k*COORD_BITS +: COORD_BITS];
	endfunction

endpackage

### rtl/core/triangle_pair_overlap_test.sv
// ----------------------------------------------------------------------------
// triangle_pair_overlap_test
// Separating axis test of two triangles over 17 exact integer axes.
// ----------------------------------------------------------------------------
// Usage:
//   pair_valid/pair_ready/pair_word carry one pair of triangles (six packed
//   vertices, x in the low bits) and a 16-bit tag. result_valid/result_ready/
//   result_word return overlaps and the tag, one result word per pair, in
//   order.
//   Throughput: one pair per cycle while the receiver does not stall.
//   Nine register stages lie between a pair being taken and its result.
//   The count is set by the chain of two cross products and the dot
//   products, each multiply followed by a register before its add.
//   Stall: all stages advance on one enable, high when the output register
//   is empty or being taken. A stalled receiver freezes the whole pipe and
//   pair_ready drops; nothing is lost or repeated. Empty stages are bubbles.
//   Reset: arst_n clears every stage valid bit; no result is pending after.
//   Zero axes (degenerate triangles, parallel edges) never separate, and
//   intervals that only touch count as overlapping.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module triangle_pair_overlap_test
	import tpot_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    pair_valid,
	output logic    pair_ready,
	input  pair_t   pair_word,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result_word
);

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic [TAG_W-1:0] tag_s1, tag_s2, tag_s3, tag_s4, tag_s5, tag_s6, tag_s7, tag_s8;
	logic out_valid_q;
	result_t result_q;

	// points: 0..2 triangle A, 3..5 triangle B, all relative to A's first vertex
	logic signed [DW-1:0] pts_s1 [N_PT][3], pts_s2 [N_PT][3], pts_s3 [N_PT][3];
	logic signed [DW-1:0] pts_s4 [N_PT][3], pts_s5 [N_PT][3];
	// edges: 0..2 triangle A, 3..5 triangle B
	logic signed [DW-1:0] edg_s1 [N_PT][3], edg_s2 [N_PT][3], edg_s3 [N_PT][3];
	logic signed [2*DW-1:0] xp_s2 [N_X1][3][2];
	logic signed [NW-1:0]   ax1_s3 [N_X1][3], ax1_s4 [N_X1][3];
	logic signed [DW+NW-1:0] np_s4 [N_X2][3][2];
	logic signed [PW-1:0]   ax_s5 [N_AX][3];
	logic signed [LOPW-1:0] lo_s6 [N_AX][N_PT-1][3];
	logic signed [HIPW-1:0] hi_s6 [N_AX][N_PT-1][3];
	logic signed [DOTW-1:0] dot_s7 [N_AX][N_PT-1];
	logic [N_AX-1:0] sep_s8;

	logic signed [COORD_BITS-1:0] raw [N_PT][3];
	logic signed [DW-1:0]   pts_d [N_PT][3], edg_d [N_PT][3];
	logic signed [2*DW-1:0] xp_d [N_X1][3][2];
	logic signed [NW-1:0]   ax1_d [N_X1][3];
	logic signed [DW+NW-1:0] np_d [N_X2][3][2];
	logic signed [PW-1:0]   ax_d [N_AX][3];
	logic signed [LOPW-1:0] lo_d [N_AX][N_PT-1][3];
	logic signed [HIPW-1:0] hi_d [N_AX][N_PT-1][3];
	logic signed [DOTW-1:0] dot_d [N_AX][N_PT-1];
	logic [N_AX-1:0] sep_d;

	assign en           = !out_valid_q || result_ready;
	assign pair_ready   = en;
	assign result_valid = out_valid_q;
	assign result_word  = result_q;

	// stage 1: unpack, translate, edges
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			raw[0][c] = coord(pair_word.vertex_a1, c);
			raw[1][c] = coord(pair_word.vertex_a2, c);
			raw[2][c] = coord(pair_word.vertex_a3, c);
			raw[3][c] = coord(pair_word.vertex_b1, c);
			raw[4][c] = coord(pair_word.vertex_b2, c);
			raw[5][c] = coord(pair_word.vertex_b3, c);
		end
		for (int i = 0; i < N_PT; i++) begin
			for (int c = 0; c < 3; c++) begin
				pts_d[i][c] = DW'(raw[i][c]) - DW'(raw[0][c]);
			end
		end
		for (int i = 0; i < 3; i++) begin
			for (int c = 0; c < 3; c++) begin
				edg_d[i][c]   = DW'(raw[NXT[i]][c]) - DW'(raw[i][c]);
				edg_d[3+i][c] = DW'(raw[3+NXT[i]][c]) - DW'(raw[3+i][c]);
			end
		end
	end

	// stage 2: products of the face normals and edge-by-edge crosses
	always_comb begin
		for (int k = 0; k < N_X1; k++) begin
			for (int c = 0; c < 3; c++) begin
				xp_d[k][c][0] = edg_s1[CROSS_L[k]][NXT[c]] * edg_s1[CROSS_R[k]][PRV[c]];
				xp_d[k][c][1] = edg_s1[CROSS_L[k]][PRV[c]] * edg_s1[CROSS_R[k]][NXT[c]];
			end
		end
	end

	// stage 3: first-level axes
	always_comb begin
		for (int k = 0; k < N_X1; k++) begin
			for (int c = 0; c < 3; c++) begin
				ax1_d[k][c] = NW'(xp_s2[k][c][0]) - NW'(xp_s2[k][c][1]);
			end
		end
	end

	// stage 4: edge by own face normal products (A uses axis 0, B axis 1)
	always_comb begin
		for (int k = 0; k < N_X2; k++) begin
			for (int c = 0; c < 3; c++) begin
				np_d[k][c][0] = edg_s3[k][NXT[c]] * ax1_s3[k / 3][PRV[c]];
				np_d[k][c][1] = edg_s3[k][PRV[c]] * ax1_s3[k / 3][NXT[c]];
			end
		end
	end

	// stage 5: all 17 axes at one width
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			for (int k = 0; k < N_X1; k++) begin
				ax_d[k][c] = PW'(ax1_s4[k][c]);
			end
			for (int k = 0; k < N_X2; k++) begin
				ax_d[N_X1+k][c] = PW'(np_s4[k][c][0]) - PW'(np_s4[k][c][1]);
			end
		end
	end

	// stage 6: split-axis partial products; point A1 is the origin and skipped
	always_comb begin
		logic signed [HW:0]      los;
		logic signed [PW-HW-1:0] his;
		los = '0;
		his = '0;
		for (int k = 0; k < N_AX; k++) begin
			for (int i = 0; i < N_PT - 1; i++) begin
				for (int c = 0; c < 3; c++) begin
					los = {1'b0, ax_s5[k][c][HW-1:0]};
					his = ax_s5[k][c][PW-1:HW];
					lo_d[k][i][c] = los * pts_s5[i+1][c];
					hi_d[k][i][c] = his * pts_s5[i+1][c];
				end
			end
		end
	end

	// stage 7: dot products
	always_comb begin
		for (int k = 0; k < N_AX; k++) begin
			for (int i = 0; i < N_PT - 1; i++) begin
				dot_d[k][i] = '0;
				for (int c = 0; c < 3; c++) begin
					dot_d[k][i] = dot_d[k][i] + (DOTW'(hi_s6[k][i][c]) <<< HW)
						+ DOTW'(lo_s6[k][i][c]);
				end
			end
		end
	end

	// stage 8: interval test per axis (A projects 0, dot 0, dot 1; B dots 2..4)
	always_comb begin
		logic signed [DOTW-1:0] amin, amax, bmin, bmax;
		amin = '0;
		amax = '0;
		bmin = '0;
		bmax = '0;
		for (int k = 0; k < N_AX; k++) begin
			amin = '0;
			amax = '0;
			if (dot_s7[k][0] < amin) amin = dot_s7[k][0];
			if (dot_s7[k][1] < amin) amin = dot_s7[k][1];
			if (dot_s7[k][0] > amax) amax = dot_s7[k][0];
			if (dot_s7[k][1] > amax) amax = dot_s7[k][1];
			bmin = dot_s7[k][2];
			bmax = dot_s7[k][2];
			for (int i = 3; i < N_PT - 1; i++) begin
				if (dot_s7[k][i] < bmin) bmin = dot_s7[k][i];
				if (dot_s7[k][i] > bmax) bmax = dot_s7[k][i];
			end
			sep_d[k] = (amin > bmax) || (bmin > amax);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1 <= pair_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			out_valid_q <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s1 <= pair_word.pair_tag;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
			tag_s5 <= tag_s4;
			tag_s6 <= tag_s5;
			tag_s7 <= tag_s6;
			tag_s8 <= tag_s7;
			pts_s1 <= pts_d;
			pts_s2 <= pts_s1;
			pts_s3 <= pts_s2;
			pts_s4 <= pts_s3;
			pts_s5 <= pts_s4;
			edg_s1 <= edg_d;
			edg_s2 <= edg_s1;
			edg_s3 <= edg_s2;
			xp_s2  <= xp_d;
			ax1_s3 <= ax1_d;
			ax1_s4 <= ax1_s3;
			np_s4  <= np_d;
			ax_s5  <= ax_d;
			lo_s6  <= lo_d;
			hi_s6  <= hi_d;
			dot_s7 <= dot_d;
			sep_s8 <= sep_d;
			result_q.overlaps   <= !(|sep_s8);
			result_q.result_tag <= tag_s8;
		end
	end

	`ASSERT_NEXT(a_take_fills_s1, pair_valid && pair_ready, v_s1,
		"accepted pair did not reach stage 1")
	`ASSERT_NEXT(a_stall_freezes, !en, $stable({v_s1, v_s4, v_s8, out_valid_q}),
		"pipeline moved while stalled")
	`ASSERT_CLK(a_out_from_s8, $rose(out_valid_q) |-> $past(v_s8),
		"result appeared without a word in stage 8")

endmodule
